// ----- rtl/text_console_char_writer_unit_assert.svh -----
// Assertion helpers for the text console writer.
// The enclosing module must have i_clk and the active low i_rst_n.
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCCW_CHECK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCCW_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition must hold in every cycle out of reset.
`define TCCW_CHECK_ALWAYS(label, cond, msg) \
    `TCCW_CHECK_IMPLY(label, 1'b1, cond, msg)

`endif

// ----- rtl/tccw_pkg.sv -----
`timescale 1ns / 1ps

package tccw_pkg;

    // Action codes of an input word
    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    // Character classes of a put
    typedef enum logic [2:0] {
        PK_PRINT = 3'd0,
        PK_BS    = 3'd1,
        PK_NL    = 3'd2,
        PK_CR    = 3'd3,
        PK_TAB   = 3'd4
    } t_put_kind;

    // Control characters
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Cell values and attribute reset
    localparam logic [15:0] BLANK_CELL = 16'h0F20;
    localparam logic [15:0] TAB_CELL   = 16'h0020;
    localparam logic [7:0]  ATTR_RESET = 8'h0F;

    // Command queue geometry (power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = 1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [4:0] target_row;
        logic [6:0] target_col;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [15:0] cell_value;
    } t_out_word;

    // Classified command, targets already clamped
    typedef struct packed {
        t_action    action;
        t_put_kind  kind;
        logic [7:0] char_code;
        logic [4:0] row;
        logic [6:0] col;
    } t_cmd;

endpackage

// ----- rtl/tccw_ram.sv -----
`timescale 1ns / 1ps

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tccw_front.sv -----
`timescale 1ns / 1ps

module tccw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tccw_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    input  logic                i_init_busy,
    input  logic                i_q_full,
    output logic                o_push,
    output tccw_pkg::t_cmd      o_cmd
);

    import tccw_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_cmd      r_cmd;
    t_cmd      n_cmd;
    logic      accept;
    logic      push;
    t_put_kind kind;

    // Hold the stage while it holds a word and the queue is full, or during the reset clearing pass
    assign o_in_stall = i_init_busy || (r_valid && i_q_full);
    assign accept     = i_in_valid && !o_in_stall;
    assign push       = r_valid && !i_q_full;

    // Classify the character
    always_comb begin
        unique case (i_in_word.char_code)
            CH_BS:   kind = PK_BS;
            CH_NL:   kind = PK_NL;
            CH_CR:   kind = PK_CR;
            CH_TAB:  kind = PK_TAB;
            default: kind = PK_PRINT;
        endcase
    end

    // Build the command word with clamped targets
    always_comb begin
        n_cmd.action    = t_action'(i_in_word.action);
        n_cmd.kind      = kind;
        n_cmd.char_code = i_in_word.char_code;
        if (int'(i_in_word.target_row) > ROWS - 1) begin
            n_cmd.row = 5'(ROWS - 1);
        end else begin
            n_cmd.row = i_in_word.target_row;
        end
        if (int'(i_in_word.target_col) > COLUMNS - 1) begin
            n_cmd.col = 7'(COLUMNS - 1);
        end else begin
            n_cmd.col = i_in_word.target_col;
        end
    end

    // Advance the stage
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push = push;
    assign o_cmd  = r_cmd;

endmodule

// ----- rtl/tccw_queue.sv -----
`timescale 1ns / 1ps

module tccw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tccw_pkg::t_cmd  i_data,
    input  logic            i_pop,
    output tccw_pkg::t_cmd  o_data,
    output logic            o_full,
    output logic            o_empty
);

    import tccw_pkg::*;

    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_PW-1:0] r_wptr;
    logic [Q_PW-1:0] r_rptr;
    logic [CW-1:0]   r_count;
    logic [Q_PW-1:0] n_wptr;
    logic [Q_PW-1:0] n_rptr;
    logic [CW-1:0]   n_count;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    // Advance pointers and fill level
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + Q_PW'(1);
        end
        if (i_pop) begin
            n_rptr = r_rptr + Q_PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/tccw_back.sv -----
`timescale 1ns / 1ps
`include "text_console_char_writer_unit_assert.svh"

module tccw_back #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_CELLS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_q_empty,
    input  tccw_pkg::t_cmd      i_q_data,
    output logic                o_q_pop,
    output logic                o_init_busy,
    output logic                o_out_valid,
    output tccw_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);

    import tccw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int TW    = $clog2(ROWS);
    localparam int TBW   = $clog2(TAB_CELLS + 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL,
        S_EXEC,
        S_READ,
        S_CLEAR,
        S_RESULT
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic [RW-1:0]  r_row;
    logic [RW-1:0]  n_row;
    logic [CW-1:0]  r_col;
    logic [CW-1:0]  n_col;
    logic [TW-1:0]  r_top;
    logic [TW-1:0]  n_top;
    logic [AW-1:0]  r_sweep;
    logic [AW-1:0]  n_sweep;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    logic [TBW-1:0] r_tab;
    logic [TBW-1:0] n_tab;
    t_cmd           r_cmd;
    t_cmd           n_cmd;
    logic [7:0]     r_attr;
    logic [7:0]     n_attr;
    logic [15:0]    r_cell;
    logic [15:0]    n_cell;
    logic           r_out_valid;
    logic           n_out_valid;
    t_out_word      r_out;
    t_out_word      n_out;

    logic           q_pop;
    logic           out_free;
    logic           fin;
    logic [15:0]    fin_cell;
    logic [RW-1:0]  w_row;
    logic [CW-1:0]  w_col;
    logic [RW-1:0]  b_row;
    logic [CW-1:0]  b_col;
    logic [RW-1:0]  a_row;
    logic [CW-1:0]  a_col;
    logic           a_sweep;
    logic [RW:0]    phys_sum;
    logic [RW:0]    phys;
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [15:0]    ram_wdata;
    logic [15:0]    ram_rdata;

    assign out_free = !r_out_valid || !i_out_stall;

    // Resolve a pending wrap ahead of a put
    always_comb begin
        w_row = r_row;
        w_col = r_col;
        if (r_col >= CW'(COLUMNS)) begin
            w_col = '0;
            w_row = r_row + RW'(1);
        end
    end

    // Backspace target
    always_comb begin
        b_row = r_row;
        b_col = r_col - CW'(1);
        if (r_col == '0) begin
            b_col = CW'(COLUMNS - 1);
            if (r_row != '0) begin
                b_row = r_row - RW'(1);
            end
        end
    end

    // Map a screen row through the circular row offset
    always_comb begin
        phys_sum = (RW+1)'(a_row) + (RW+1)'(r_top);
        if (phys_sum >= (RW+1)'(ROWS)) begin
            phys = phys_sum - (RW+1)'(ROWS);
        end else begin
            phys = phys_sum;
        end
        if (a_sweep) begin
            ram_addr = r_sweep;
        end else begin
            ram_addr = AW'(AW'(phys) * AW'(COLUMNS)) + AW'(a_col);
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_top       = r_top;
        n_sweep     = r_sweep;
        n_cnt       = r_cnt;
        n_tab       = r_tab;
        n_cmd       = r_cmd;
        n_cell      = r_cell;
        n_attr      = i_cfg_we ? i_cfg_wdata : r_attr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = BLANK_CELL;
        a_row       = r_row;
        a_col       = r_col;
        a_sweep     = 1'b0;
        fin         = 1'b0;
        fin_cell    = '0;

        unique case (r_state)
            S_INIT: begin
                a_sweep = 1'b1;
                ram_we  = 1'b1;
                if (r_sweep == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    q_pop   = 1'b1;
                    n_cmd   = i_q_data;
                    n_tab   = '0;
                    n_state = S_EXEC;
                    if (i_q_data.action == ACT_PUT) begin
                        n_row = w_row;
                        n_col = w_col;
                        // Pending scroll: bump the top row, then blank the new bottom
                        if (w_row >= RW'(ROWS)) begin
                            n_row   = RW'(ROWS - 1);
                            n_top   = (r_top == TW'(ROWS - 1)) ? '0 : r_top + TW'(1);
                            n_cnt   = '0;
                            n_state = S_SCROLL;
                        end
                    end
                end
            end
            S_SCROLL: begin
                a_col  = r_cnt;
                ram_we = 1'b1;
                if (r_cnt == CW'(COLUMNS - 1)) begin
                    n_state = S_EXEC;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_EXEC: begin
                unique case (r_cmd.action)
                    ACT_PUT: begin
                        unique case (r_cmd.kind)
                            PK_BS: begin
                                n_row  = b_row;
                                n_col  = b_col;
                                a_row  = b_row;
                                a_col  = b_col;
                                ram_we = 1'b1;
                                fin    = 1'b1;
                            end
                            PK_NL: begin
                                n_row = r_row + RW'(1);
                                n_col = '0;
                                fin   = 1'b1;
                            end
                            PK_TAB: begin
                                if (r_tab < TBW'(TAB_CELLS) && r_col < CW'(COLUMNS)) begin
                                    ram_we    = 1'b1;
                                    ram_wdata = TAB_CELL;
                                    n_col     = r_col + CW'(1);
                                    n_tab     = r_tab + TBW'(1);
                                end else begin
                                    fin = 1'b1;
                                end
                            end
                            PK_PRINT: begin
                                ram_we    = 1'b1;
                                ram_wdata = {r_attr, r_cmd.char_code};
                                n_col     = r_col + CW'(1);
                                fin       = 1'b1;
                            end
                            default: begin
                                fin = 1'b1;
                            end
                        endcase
                    end
                    ACT_SET: begin
                        n_row = RW'(r_cmd.row);
                        n_col = CW'(r_cmd.col);
                        fin   = 1'b1;
                    end
                    ACT_CLEAR: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_top   = '0;
                        n_sweep = '0;
                        n_state = S_CLEAR;
                    end
                    ACT_READ: begin
                        a_row   = RW'(r_cmd.row);
                        a_col   = CW'(r_cmd.col);
                        n_state = S_READ;
                    end
                endcase
            end
            S_READ: begin
                fin      = 1'b1;
                fin_cell = ram_rdata;
            end
            S_CLEAR: begin
                a_sweep = 1'b1;
                ram_we  = 1'b1;
                if (r_sweep == AW'(CELLS - 1)) begin
                    fin = 1'b1;
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.cursor_row = 5'(r_row);
                    n_out.cursor_col = 7'(r_col);
                    n_out.cell_value = r_cell;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result word, or park it until the output register frees
        if (fin) begin
            if (out_free) begin
                n_out_valid      = 1'b1;
                n_out.cursor_row = 5'(n_row);
                n_out.cursor_col = 7'(n_col);
                n_out.cell_value = fin_cell;
                n_state          = S_IDLE;
            end else begin
                n_cell  = fin_cell;
                n_state = S_RESULT;
            end
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_sweep     <= '0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_top       <= n_top;
            r_sweep     <= n_sweep;
            r_attr      <= n_attr;
            r_out_valid <= n_out_valid;
        end
        r_cnt  <= n_cnt;
        r_tab  <= n_tab;
        r_cmd  <= n_cmd;
        r_cell <= n_cell;
        r_out  <= n_out;
    end

    tccw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    assign o_q_pop     = q_pop;
    assign o_init_busy = (r_state == S_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `TCCW_CHECK_IMPLY(a_pop_nonempty, q_pop, !i_q_empty, "command popped from an empty queue")
    `TCCW_CHECK_ALWAYS(a_col_range, r_col <= CW'(COLUMNS), "cursor column beyond wrap position")
    `TCCW_CHECK_ALWAYS(a_row_range, r_row <= RW'(ROWS), "cursor row beyond scroll position")
    `TCCW_CHECK_IMPLY(a_init_quiet, r_state == S_INIT, !r_out_valid, "result during clearing pass")
    `TCCW_CHECK_NEXT(a_scroll_end, (r_state == S_SCROLL) && (r_cnt == CW'(COLUMNS - 1)),
        r_state == S_EXEC, "scroll did not hand over to execution")

endmodule

// ----- rtl/text_console_char_writer_unit.sv -----
`timescale 1ns / 1ps
// Text console writer: an 80x25 screen of attribute/character cells plus a cursor.
// Input channel (i_in_valid / o_in_stall / i_in_word): one word per action - put
// a character, set the cursor, clear the screen, or read one cell.
// Output channel (o_out_valid / i_out_stall / o_out_word): exactly one result word
// per input word, in order: cursor row and column after the action, and the cell
// read (zero for other actions).
// i_cfg_we / i_cfg_wdata set the attribute byte used for printed characters.
// A front stage classifies and clamps each word into a two-entry command queue;
// the back sequencer owns the screen memory and the cursor.
// The back runs one command at a time, going from idle to execution, while the front
// stage and queue hold further words; a read adds a read state, a tab writes up to
// TAB_CELLS space cells, a put that scrolls first blanks the new bottom row, and a
// clear writes every cell blank. Each word passes the front stage and the queue first.
// After reset a clearing pass writes all ROWS*COLUMNS cells blank (2000 by default)
// with o_in_stall high; configuration writes are taken during it.
// While i_out_stall is high the result word holds; the back stops at its next result
// and the queue fills, then o_in_stall rises.
module text_console_char_writer_unit #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_CELLS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tccw_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output tccw_pkg::t_out_word o_out_word,
    input  logic                i_out_stall,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata
);

    import tccw_pkg::*;

    logic init_busy;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd pop_cmd;

    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .i_init_busy (init_busy),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    tccw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tccw_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_CELLS (TAB_CELLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_q_data    (pop_cmd),
        .o_q_pop     (pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule
